/* hw/rtl/lsf_pkg.sv */
package lsf_pkg;

    // Default sizes of the line store, line buffer and search pattern
    localparam int MAX_LINES_DEF   = 512;
    localparam int LINE_BYTES_DEF  = 72;
    localparam int PATTERN_MAX_DEF = 32;

    // Field widths of the configuration port and the result
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int PLEN_REG_W    = 6;
    localparam int LINE_NUMBER_W = 9;
    localparam int POSITION_W    = 7;
    localparam int ORDINAL_W     = 9;

    typedef logic [7:0] byte_t;

    localparam byte_t NEWLINE_BYTE = 8'h0A;
    localparam byte_t NUL_BYTE     = 8'h00;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_0_7    = 3'd1,
        REG_PATTERN_8_15   = 3'd2,
        REG_PATTERN_16_23  = 3'd3,
        REG_PATTERN_24_31  = 3'd4
    } cfg_reg_t;

endpackage

/* hw/rtl/lsf_match.sv */
module lsf_match
    import lsf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    localparam int PLEN_W = $clog2(PATTERN_MAX + 1),
    localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
)
(
    input  byte_t             window [PATTERN_MAX],
    input  byte_t             pattern [PATTERN_MAX],
    input  logic [PLEN_W-1:0] plen,
    output logic              all_equal
);

    logic [PIDX_W-1:0] idx;

    // Compare pattern byte j against the window entry plen-1-j (newest at 0)
    always_comb
    begin
        all_equal = 1'b1;
        idx       = '0;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if (PLEN_W'(j) < plen)
            begin
                idx = PIDX_W'(plen - PLEN_W'(j) - PLEN_W'(1));
                if (pattern[j] == NUL_BYTE || pattern[j] != window[idx])
                begin
                    all_equal = 1'b0;
                end
            end
        end
    end

endmodule

/* hw/rtl/line_substring_filter_unit.sv */
// Channel   | Signals                                   | Transfer
// ----------+-------------------------------------------+---------------------------
// in        | in_valid, in_ready, data_byte, end_of_file| in_valid & in_ready
// out       | out_valid, out_ready, line_number,        | out_valid & out_ready
//           | line_matches, first_position,             |
//           | match_ordinal, final_line                 |
// cfg       | cfg_we, cfg_index, cfg_data               | cfg_we
//
// One byte per cycle sustained while the result side does not stall; a result is
// registered into the result register from the byte held in the input register.
// The window compare against all pattern bytes settles in the cycle the byte is
// processed, so the line state loop closes within that cycle.
// Reset clears the counters, line state and all configuration registers; no
// clearing pass is needed.
// A held result with out_ready low stalls the input register and thus in_ready.
module line_substring_filter_unit
    import lsf_pkg::*;
#(
    parameter int MAX_LINES   = MAX_LINES_DEF,
    parameter int LINE_BYTES  = LINE_BYTES_DEF,
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  byte_t                    data_byte,
    input  logic                     end_of_file,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [LINE_NUMBER_W-1:0] line_number,
    output logic                     line_matches,
    output logic [POSITION_W-1:0]    first_position,
    output logic [ORDINAL_W-1:0]     match_ordinal,
    output logic                     final_line
);

    localparam int COL_W  = $clog2(LINE_BYTES);
    localparam int LN_W   = $clog2(MAX_LINES + 1);
    localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
    localparam int CMP_W  = (COL_W + 1 > PLEN_W) ? COL_W + 1 : PLEN_W;

    // Configuration registers
    logic [PLEN_REG_W-1:0] pattern_length_reg;
    byte_t                 pattern_reg [PATTERN_MAX];

    // Input register
    logic                  s1_valid_reg;
    byte_t                 s1_byte_reg;
    logic                  s1_eof_reg;

    // Line and file state
    logic [COL_W-1:0]      column_reg;
    logic [COL_W-1:0]      column_next;
    logic                  found_reg;
    logic                  found_next;
    logic [COL_W-1:0]      found_col_reg;
    logic [COL_W-1:0]      found_col_next;
    logic                  zero_seen_reg;
    logic                  zero_seen_next;
    logic [LN_W-1:0]       lines_done_reg;
    logic [LN_W-1:0]       lines_done_next;
    logic [LN_W-1:0]       matches_done_reg;
    logic [LN_W-1:0]       matches_done_next;
    byte_t                 window_reg [PATTERN_MAX];
    byte_t                 window_shifted [PATTERN_MAX];

    // Result register
    logic                     out_valid_reg;
    logic [LINE_NUMBER_W-1:0] line_number_reg;
    logic                     line_matches_reg;
    logic [POSITION_W-1:0]    first_position_reg;
    logic [ORDINAL_W-1:0]     match_ordinal_reg;
    logic                     final_line_reg;

    // Datapath signals
    logic                  in_xfer;
    logic                  advance;
    logic [PLEN_W-1:0]     plen;
    logic                  active;
    logic                  is_newline;
    logic [COL_W:0]        col_inc;
    logic                  take;
    logic                  shift_en;
    logic                  try_hit;
    logic                  all_equal;
    logic                  hit;
    logic [COL_W-1:0]      column_after;
    logic                  zero_after;
    logic                  found_after;
    logic [COL_W-1:0]      found_col_after;
    logic                  finish;
    logic                  line_hit;

    // Handshake: process the held byte when the result slot is free
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    assign out_valid      = out_valid_reg;
    assign line_number    = line_number_reg;
    assign line_matches   = line_matches_reg;
    assign first_position = first_position_reg;
    assign match_ordinal  = match_ordinal_reg;
    assign final_line     = final_line_reg;

    // Write the pattern length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
        end
        else if (cfg_we && cfg_index == REG_PATTERN_LENGTH)
        begin
            pattern_length_reg <= cfg_data[PLEN_REG_W-1:0];
        end
    end

    // Write pattern bytes; byte k lives in register index 1 + k/8 at bit 8*(k%8)
    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_pattern
        localparam logic [CFG_IDX_W-1:0] BYTE_REG =
            CFG_IDX_W'(REG_PATTERN_0_7) + CFG_IDX_W'(k / 8);
        localparam int BYTE_LSB = (k % 8) * 8;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pattern_reg[k] <= NUL_BYTE;
            end
            else if (cfg_we && cfg_index == BYTE_REG)
            begin
                pattern_reg[k] <= cfg_data[BYTE_LSB +: 8];
            end
        end
    end

    // Clamp the pattern length to the supported maximum
    always_comb
    begin
        if (pattern_length_reg > PLEN_REG_W'(PATTERN_MAX))
        begin
            plen = PLEN_W'(PATTERN_MAX);
        end
        else
        begin
            plen = PLEN_W'(pattern_length_reg);
        end
    end

    // Window as it stands after the new byte enters at position 0
    always_comb
    begin
        window_shifted[0] = s1_byte_reg;
        for (int i = 1; i < PATTERN_MAX; i++)
        begin
            window_shifted[i] = window_reg[i-1];
        end
    end

    lsf_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .window    (window_shifted),
        .pattern   (pattern_reg),
        .plen      (plen),
        .all_equal (all_equal)
    );

    // Line tracking and result fields for the held byte
    always_comb
    begin
        active     = lines_done_reg < LN_W'(MAX_LINES);
        is_newline = s1_byte_reg == NEWLINE_BYTE;
        col_inc    = {1'b0, column_reg} + (COL_W + 1)'(1);
        take       = active && !is_newline && (column_reg < COL_W'(LINE_BYTES - 1));
        shift_en   = take && !zero_seen_reg && (s1_byte_reg != NUL_BYTE);
        try_hit    = shift_en && !found_reg && (plen != '0)
                     && (CMP_W'(col_inc) >= CMP_W'(plen));
        hit        = try_hit && all_equal;

        column_after    = take ? COL_W'(col_inc) : column_reg;
        zero_after      = zero_seen_reg || (take && s1_byte_reg == NUL_BYTE);
        found_after     = found_reg || hit;
        found_col_after = hit ? COL_W'(CMP_W'(col_inc) - CMP_W'(plen)) : found_col_reg;

        finish   = active && (is_newline || (s1_eof_reg && column_after != '0));
        line_hit = found_after && (plen != '0);

        // Clear the line at its end or at the end of the file
        if (finish || s1_eof_reg)
        begin
            column_next    = '0;
            found_next     = 1'b0;
            found_col_next = '0;
            zero_seen_next = 1'b0;
        end
        else
        begin
            column_next    = column_after;
            found_next     = found_after;
            found_col_next = found_col_after;
            zero_seen_next = zero_after;
        end

        if (s1_eof_reg)
        begin
            lines_done_next   = '0;
            matches_done_next = '0;
        end
        else
        begin
            lines_done_next   = finish ? lines_done_reg + LN_W'(1) : lines_done_reg;
            matches_done_next = (finish && line_hit) ? matches_done_reg + LN_W'(1)
                                                     : matches_done_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            column_reg       <= '0;
            found_reg        <= 1'b0;
            found_col_reg    <= '0;
            zero_seen_reg    <= 1'b0;
            lines_done_reg   <= '0;
            matches_done_reg <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= finish;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                column_reg       <= column_next;
                found_reg        <= found_next;
                found_col_reg    <= found_col_next;
                zero_seen_reg    <= zero_seen_next;
                lines_done_reg   <= lines_done_next;
                matches_done_reg <= matches_done_next;
            end
        end
    end

    // Capture the input byte
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_byte_reg <= data_byte;
            s1_eof_reg  <= end_of_file;
        end
    end

    // Advance the character window
    always_ff @(posedge clk)
    begin
        if (advance && shift_en)
        begin
            window_reg <= window_shifted;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (advance && finish)
        begin
            line_number_reg    <= LINE_NUMBER_W'(lines_done_reg);
            line_matches_reg   <= line_hit;
            first_position_reg <= line_hit ? POSITION_W'(found_col_after) : '0;
            match_ordinal_reg  <= line_hit ? ORDINAL_W'(matches_done_reg) : '0;
            final_line_reg     <= s1_eof_reg;
        end
    end

endmodule

/* hw/rtl/lsf_checker.sv */
module lsf_checker
    import lsf_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input byte_t                    data_byte,
    input logic                     end_of_file,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [LINE_NUMBER_W-1:0] line_number,
    input logic                     line_matches,
    input logic [POSITION_W-1:0]    first_position,
    input logic [ORDINAL_W-1:0]     match_ordinal,
    input logic                     final_line
);

    logic out_xfer;
    logic file_start_reg;
    logic no_match_yet_reg;

    assign out_xfer = out_valid && out_ready;

    // Track the first line and the first match of each file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_start_reg   <= 1'b1;
            no_match_yet_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            file_start_reg   <= final_line;
            no_match_yet_reg <= final_line || (no_match_yet_reg && !line_matches);
        end
    end

    // Hold a stalled input byte
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(end_of_file))
        else $error("input byte changed while stalled");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(line_number)
            && $stable(line_matches) && $stable(first_position)
            && $stable(match_ordinal) && $stable(final_line))
        else $error("result changed while stalled");

    // A line without a match carries no position and no ordinal
    a_no_match_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_matches |-> first_position == '0 && match_ordinal == '0)
        else $error("non-matching line has match fields set");

    // The first result of a file is line 0
    a_first_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && file_start_reg |-> line_number == '0)
        else $error("first line of a file is not line 0");

    // The first matching line of a file has ordinal 0
    a_first_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && line_matches && no_match_yet_reg |-> match_ordinal == '0)
        else $error("first match of a file has nonzero ordinal");

endmodule

bind line_substring_filter_unit lsf_checker u_lsf_checker (.*);

/* sim/line_substring_filter_unit_tb.sv */
`timescale 1ns / 1ps

module line_substring_filter_unit_tb;
    import lsf_pkg::*;

    localparam int MAX_LINES       = MAX_LINES_DEF;
    localparam int LINE_BYTES      = LINE_BYTES_DEF;
    localparam int PATTERN_MAX     = PATTERN_MAX_DEF;
    localparam int WINDOW_DEPTH    = 32;
    localparam int DRAIN_CYCLES    = 4;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int RANDOM_BYTES    = 200;
    localparam int MAX_REPORTED    = 10;

    typedef struct packed {
        logic [LINE_NUMBER_W-1:0] line_number;
        logic                     line_matches;
        logic [POSITION_W-1:0]    first_position;
        logic [ORDINAL_W-1:0]     match_ordinal;
        logic                     final_line;
    } line_report_t;

    // One row of the directed table: a register write or a byte transfer
    typedef struct packed {
        logic                  is_cfg;
        cfg_reg_t              reg_sel;
        logic [CFG_DATA_W-1:0] value;
        byte_t                 data;
        logic                  eof;
        logic                  typed;
        line_report_t          report;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    byte_t                    data_byte = '0;
    logic                     end_of_file = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [LINE_NUMBER_W-1:0] line_number;
    logic                     line_matches;
    logic [POSITION_W-1:0]    first_position;
    logic [ORDINAL_W-1:0]     match_ordinal;
    logic                     final_line;

    // Line filter shadow state and pattern registers
    logic [PLEN_REG_W-1:0]    pat_len_reg = '0;
    logic [CFG_DATA_W-1:0]    pat_words [4] = '{default: '0};
    byte_t                    window [WINDOW_DEPTH] = '{default: '0};
    int unsigned              col_count = 0;
    int unsigned              lines_seen = 0;
    int unsigned              matches_seen = 0;
    int unsigned              hit_column = 0;
    bit                       hit_found = 1'b0;
    bit                       nul_seen = 1'b0;

    line_report_t             pending_reports [$];
    byte_t                    tb_pattern [PATTERN_MAX] = '{default: '0};
    int unsigned              pattern_len_sel = 0;
    int unsigned              bytes_sent = 0;
    int unsigned              reports_checked = 0;
    int unsigned              mismatch_count = 0;
    bit                       idle_on = 1'b1;
    bit                       hold_off_req = 1'b0;

    line_substring_filter_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_file    (end_of_file),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .line_number    (line_number),
        .line_matches   (line_matches),
        .first_position (first_position),
        .match_ordinal  (match_ordinal),
        .final_line     (final_line)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pattern length in use, clipped to the compare window
    function automatic int unsigned used_pattern_length();
        int unsigned n;
        n = 32'(pat_len_reg);
        if (n > PATTERN_MAX)
            n = PATTERN_MAX;
        return n;
    endfunction

    function automatic byte_t pattern_char(input int unsigned k);
        return pat_words[k / 8][(k % 8) * 8 +: 8];
    endfunction

    function automatic void clear_line();
        int i;
        col_count  = 0;
        hit_found  = 1'b0;
        hit_column = 0;
        nul_seen   = 1'b0;
        for (i = 0; i < WINDOW_DEPTH; i++)
            window[i] = '0;
    endfunction

    // Close the open line and build its report
    function automatic void close_line(input bit last, output line_report_t rpt);
        bit m;
        m = hit_found && (used_pattern_length() != 0);
        rpt.line_number    = lines_seen[LINE_NUMBER_W-1:0];
        rpt.line_matches   = m;
        rpt.first_position = m ? hit_column[POSITION_W-1:0] : '0;
        rpt.match_ordinal  = m ? matches_seen[ORDINAL_W-1:0] : '0;
        rpt.final_line     = last;
        if (m)
            matches_seen++;
        lines_seen++;
        clear_line();
    endfunction

    // Advance the shadow state by one byte; return 1 when a line report results
    function automatic bit predict_byte(input byte_t b, input logic eof,
                                        output line_report_t rpt);
        bit          produced;
        bit          hit;
        int unsigned col;
        int unsigned plen;
        int unsigned i;
        int unsigned j;
        produced = 1'b0;
        rpt = '0;
        if (lines_seen < MAX_LINES)
        begin
            if (b == NEWLINE_BYTE)
            begin
                close_line(eof, rpt);
                produced = 1'b1;
            end
            else
            begin
                // keep the byte only while the line has room
                if (col_count < LINE_BYTES - 1)
                begin
                    col = col_count;
                    col_count = col + 1;
                    if (!nul_seen && b == NUL_BYTE)
                        nul_seen = 1'b1;
                    else if (!nul_seen)
                    begin
                        for (i = WINDOW_DEPTH - 1; i > 0; i--)
                            window[i] = window[i-1];
                        window[0] = b;
                        plen = used_pattern_length();
                        if (!hit_found && plen != 0 && col + 1 >= plen)
                        begin
                            hit = 1'b1;
                            for (j = 0; j < plen; j++)
                            begin
                                if (pattern_char(j) == NUL_BYTE ||
                                    pattern_char(j) != window[plen-1-j])
                                    hit = 1'b0;
                            end
                            if (hit)
                            begin
                                hit_found  = 1'b1;
                                hit_column = col + 1 - plen;
                            end
                        end
                    end
                end
                if (eof && col_count > 0)
                begin
                    close_line(1'b1, rpt);
                    produced = 1'b1;
                end
            end
        end
        if (eof)
        begin
            clear_line();
            lines_seen   = 0;
            matches_seen = 0;
        end
        return produced;
    endfunction

    function automatic string report_text(input line_report_t r);
        return $sformatf("line %0d match %0b pos %0d ord %0d final %0b",
                         r.line_number, r.line_matches, r.first_position,
                         r.match_ordinal, r.final_line);
    endfunction

    function automatic void note_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTED)
            $display("[%0t] MISMATCH %s", $time, msg);
        mismatch_count++;
    endfunction

    function automatic stim_row_t cfg_row(input cfg_reg_t sel,
                                          input logic [CFG_DATA_W-1:0] value);
        stim_row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_sel = sel;
        r.value   = value;
        return r;
    endfunction

    function automatic stim_row_t byte_row(input byte_t b, input logic eof);
        stim_row_t r;
        r = '0;
        r.data = b;
        r.eof  = eof;
        return r;
    endfunction

    function automatic stim_row_t checked_row(input byte_t b, input logic eof,
                                              input int ln, input bit m, input int pos,
                                              input int ord, input bit fin);
        stim_row_t r;
        r = byte_row(b, eof);
        r.typed                 = 1'b1;
        r.report.line_number    = ln[LINE_NUMBER_W-1:0];
        r.report.line_matches   = m;
        r.report.first_position = pos[POSITION_W-1:0];
        r.report.match_ordinal  = ord[ORDINAL_W-1:0];
        r.report.final_line     = fin;
        return r;
    endfunction

    // Mostly the pattern alphabet, with some zero, all-ones and raw bytes
    function automatic byte_t text_byte();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return byte_t'(8'h61 + $urandom_range(0, 2));
        else if (pick == 14)
            return NUL_BYTE;
        else if (pick == 15)
            return 8'hFF;
        return byte_t'($urandom_range(0, 255));
    endfunction

    // Drop valid and wait until every report is in and the pipeline is empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        cfg_we   <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        if (sel == REG_PATTERN_LENGTH)
            pat_len_reg = value[PLEN_REG_W-1:0];
        else
            pat_words[int'(sel) - int'(REG_PATTERN_0_7)] = value;
        @(posedge clk);
    endtask

    // Offer one byte, hold it until the transfer, then predict its report
    task automatic send_byte(input byte_t b, input logic eof, input bit typed = 1'b0,
                             input line_report_t typed_rpt = '0);
        line_report_t rpt;
        bit           produced;
        cfg_we <= 1'b0;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_file <= eof;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        produced = predict_byte(b, eof, rpt);
        if (typed)
            pending_reports.push_back(typed_rpt);
        else if (produced)
            pending_reports.push_back(rpt);
        bytes_sent++;
    endtask

    task automatic load_pattern();
        logic [CFG_DATA_W-1:0] word;
        int                    w;
        int                    k;
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(pattern_len_sel));
        for (w = 0; w < 4; w++)
        begin
            for (k = 0; k < 8; k++)
                word[k*8 +: 8] = tb_pattern[w*8 + k];
            write_reg(cfg_reg_t'(int'(REG_PATTERN_0_7) + w), word);
        end
    endtask

    // Send one line, optionally with the pattern planted at a random column
    task automatic send_line(input int len, input bit embed, input bit last,
                             input bit eof_on_nl);
        byte_t text [$];
        int    span;
        int    at;
        int    i;
        for (i = 0; i < len; i++)
            text.push_back(text_byte());
        span = (pattern_len_sel > PATTERN_MAX) ? PATTERN_MAX : pattern_len_sel;
        if (embed && span > 0)
        begin
            at = $urandom_range(0, len);
            while (text.size() < at + span)
                text.push_back(text_byte());
            for (i = 0; i < span; i++)
                text[at + i] = tb_pattern[i];
        end
        if (last && !eof_on_nl && text.size() > 0)
        begin
            for (i = 0; i < text.size() - 1; i++)
                send_byte(text[i], 1'b0);
            send_byte(text[text.size() - 1], 1'b1);
        end
        else
        begin
            for (i = 0; i < text.size(); i++)
                send_byte(text[i], 1'b0);
            send_byte(NEWLINE_BYTE, last);
        end
    endtask

    // One random file: new pattern, then lines around it or raw noise
    task automatic random_file();
        int unsigned k;
        int          n_lines;
        int          i;
        bit          closes;
        bit          eof_on_nl;
        wait_idle();
        k = $urandom_range(0, 9);
        if (k == 0)
            pattern_len_sel = 0;
        else if (k == 1)
            pattern_len_sel = $urandom_range(PATTERN_MAX, 63);
        else if (k < 5)
            pattern_len_sel = $urandom_range(1, PATTERN_MAX);
        else
            pattern_len_sel = $urandom_range(1, 4);
        for (i = 0; i < PATTERN_MAX; i++)
            tb_pattern[i] = ($urandom_range(0, 7) == 0) ? byte_t'($urandom_range(1, 255))
                                                          : byte_t'(8'h61 + $urandom_range(0, 2));
        if ($urandom_range(0, 9) == 0)
            tb_pattern[$urandom_range(0, PATTERN_MAX - 1)] = NUL_BYTE;
        load_pattern();
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(5, 40))
                send_byte(byte_t'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
        else
        begin
            n_lines   = $urandom_range(1, 6);
            closes    = ($urandom_range(0, 3) != 0);
            eof_on_nl = ($urandom_range(0, 1) == 1);
            for (i = 0; i < n_lines; i++)
                send_line(($urandom_range(0, 9) == 0) ? $urandom_range(60, 90)
                                                       : $urandom_range(0, 12),
                          $urandom_range(0, 1) == 1, closes && (i == n_lines - 1),
                          eof_on_nl);
        end
    endtask

    // Compare each report transfer against the oldest prediction
    always @(posedge clk)
    begin : result_check
        line_report_t got;
        line_report_t want;
        string        bad;
        if (rst_n && out_valid && out_ready)
        begin
            got = {line_number, line_matches, first_position, match_ordinal, final_line};
            if (pending_reports.size() == 0)
                note_mismatch({"report with none expected: ", report_text(got)});
            else
            begin
                want = pending_reports.pop_front();
                bad = "";
                if (got.line_number !== want.line_number)
                    bad = {bad, " line_number"};
                if (got.line_matches !== want.line_matches)
                    bad = {bad, " line_matches"};
                if (got.first_position !== want.first_position)
                    bad = {bad, " first_position"};
                if (got.match_ordinal !== want.match_ordinal)
                    bad = {bad, " match_ordinal"};
                if (got.final_line !== want.final_line)
                    bad = {bad, " final_line"};
                if (bad != "")
                    note_mismatch({"on", bad, ": expected ", report_text(want),
                                   ", got ", report_text(got)});
                reports_checked++;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        stim_row_t   directed_rows [$];
        stim_row_t   row;
        bit          prev_cfg;
        int unsigned target;
        int          i;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Filter off after reset
        directed_rows.push_back(byte_row(8'h61, 1'b0));
        directed_rows.push_back(checked_row(NEWLINE_BYTE, 1'b0, 0, 0, 0, 0, 0));
        // Two-byte pattern "ab", unused words at both extremes
        directed_rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd2));
        directed_rows.push_back(cfg_row(REG_PATTERN_0_7, 64'h6261));
        directed_rows.push_back(cfg_row(REG_PATTERN_8_15, '1));
        directed_rows.push_back(cfg_row(REG_PATTERN_16_23, '0));
        directed_rows.push_back(cfg_row(REG_PATTERN_24_31, '1));
        directed_rows.push_back(byte_row(8'h78, 1'b0));
        directed_rows.push_back(byte_row(8'h61, 1'b0));
        directed_rows.push_back(byte_row(8'h62, 1'b0));
        directed_rows.push_back(checked_row(NEWLINE_BYTE, 1'b0, 1, 1, 1, 0, 0));
        // A zero byte hides the rest of the line
        directed_rows.push_back(byte_row(NUL_BYTE, 1'b0));
        directed_rows.push_back(byte_row(8'h61, 1'b0));
        directed_rows.push_back(byte_row(8'h62, 1'b0));
        directed_rows.push_back(checked_row(NEWLINE_BYTE, 1'b0, 2, 0, 0, 0, 0));
        // Unterminated last line that matches
        directed_rows.push_back(byte_row(8'hFF, 1'b0));
        directed_rows.push_back(byte_row(8'h61, 1'b0));
        directed_rows.push_back(checked_row(8'h62, 1'b1, 3, 1, 1, 1, 1));
        // Length above the maximum clips to a full 32-byte pattern
        directed_rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd63));
        directed_rows.push_back(cfg_row(REG_PATTERN_0_7, '1));
        directed_rows.push_back(cfg_row(REG_PATTERN_16_23, '1));
        directed_rows.push_back(byte_row(8'hFF, 1'b0));
        directed_rows.push_back(checked_row(NEWLINE_BYTE, 1'b0, 0, 0, 0, 0, 0));
        // A zero byte inside the pattern never matches
        directed_rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd3));
        directed_rows.push_back(cfg_row(REG_PATTERN_0_7, 64'h00_6161));
        directed_rows.push_back(byte_row(8'h61, 1'b0));
        directed_rows.push_back(byte_row(8'h61, 1'b0));
        directed_rows.push_back(byte_row(8'h61, 1'b0));
        directed_rows.push_back(checked_row(NEWLINE_BYTE, 1'b0, 1, 0, 0, 0, 0));
        directed_rows.push_back(checked_row(NEWLINE_BYTE, 1'b1, 2, 0, 0, 0, 1));
        // Pattern rewritten mid-line: the hit already found stays
        directed_rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd1));
        directed_rows.push_back(cfg_row(REG_PATTERN_0_7, 64'h7A));
        directed_rows.push_back(byte_row(8'h7A, 1'b0));
        directed_rows.push_back(cfg_row(REG_PATTERN_0_7, 64'h79));
        directed_rows.push_back(checked_row(NEWLINE_BYTE, 1'b0, 0, 1, 0, 0, 0));
        // Filter switched off after a hit: no match at line end
        directed_rows.push_back(byte_row(8'h79, 1'b0));
        directed_rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd0));
        directed_rows.push_back(checked_row(NEWLINE_BYTE, 1'b0, 1, 0, 0, 0, 0));
        directed_rows.push_back(checked_row(8'h41, 1'b1, 2, 0, 0, 0, 1));

        prev_cfg = 1'b0;
        for (i = 0; i < directed_rows.size(); i++)
        begin
            row = directed_rows[i];
            if (row.is_cfg)
            begin
                if (!prev_cfg)
                    wait_idle();
                write_reg(row.reg_sel, row.value);
            end
            else
                send_byte(row.data, row.eof, row.typed, row.report);
            prev_cfg = row.is_cfg;
        end

        // First half of the random files
        target = bytes_sent + RANDOM_BYTES / 2;
        while (bytes_sent < target)
            random_file();

        // Overfill the line store while the result side holds off
        wait_idle();
        pattern_len_sel = 1;
        tb_pattern[0] = 8'h61;
        load_pattern();
        hold_off_req = 1'b1;
        repeat (MAX_LINES + 4)
            send_line(0, 1'b0, 1'b0, 1'b0);
        repeat (8)
            send_byte(byte_t'($urandom_range(0, 255)), 1'b0);
        send_byte(8'h41, 1'b1);

        // Second half; the tail runs without idling
        target = bytes_sent + RANDOM_BYTES / 2;
        while (bytes_sent < target)
        begin
            if (bytes_sent + 50 > target)
                idle_on = 1'b0;
            random_file();
        end

        wait_idle();
        $display("Ran %0d input bytes and checked %0d line reports over many pattern settings,",
                 bytes_sent, reports_checked);
        $display("including overlong lines, zero bytes, a full line store and a long output hold.");
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Timeout waiting for the line filter to finish");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/lsf_pkg.sv
hw/rtl/lsf_match.sv
hw/rtl/line_substring_filter_unit.sv
hw/rtl/lsf_checker.sv
sim/line_substring_filter_unit_tb.sv
